@@ design/assert_macros.svh @@
// Assertion macros shared by the reply reorder buffer RTL.
// No dependencies; the including module must provide clk_i and rst_ni.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property, disabled while reset is asserted.
`define ASSERT_CLK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Condition that must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(lbl, cond, msg) \
  `ASSERT_CLK(lbl, 1'b1 |-> (cond), msg)

`endif

@@ design/rrb_pkg.sv @@
// Package of the reply reorder buffer: request and result structs, entry layout, codes.
// No dependencies; used by rrb_entry_ram and reply_reorder_buffer.
`default_nettype none

package rrb_pkg;

  localparam int unsigned DEPTH_DEFAULT = 16;
  // At most this many replies leave the ring per drain request.
  localparam int unsigned MAX_DRAIN = 16;
  localparam int unsigned DRAIN_W = $clog2(MAX_DRAIN);

  // Request commands.
  localparam logic [2:0] CMD_RESERVE = 3'd0;
  localparam logic [2:0] CMD_FILL    = 3'd1;
  localparam logic [2:0] CMD_BEGIN   = 3'd2;
  localparam logic [2:0] CMD_PART    = 3'd3;
  localparam logic [2:0] CMD_COUNT   = 3'd4;
  localparam logic [2:0] CMD_DRAIN   = 3'd5;

  // Result kinds.
  localparam logic [1:0] RES_GRANT   = 2'd0;
  localparam logic [1:0] RES_FULL    = 2'd1;
  localparam logic [1:0] RES_DRAINED = 2'd2;
  localparam logic [1:0] RES_NONE    = 2'd3;

  // Reply kind of a plain filled entry; aggregates use their kind plus one.
  localparam logic [2:0] RK_PLAIN = 3'd0;

  typedef struct packed {
    logic [2:0]         command;
    logic [31:0]        slot_number;
    logic [31:0]        payload;
    logic [1:0]         agg_kind;
    logic [7:0]         parts_expected;
    logic signed [63:0] count_value;
  } req_t;

  typedef struct packed {
    logic [1:0]         result_kind;
    logic [31:0]        slot_number_res;
    logic [2:0]         reply_kind;
    logic [31:0]        payload_res;
    logic signed [63:0] count_value_res;
    logic               last;
  } rsp_t;

  // One word of the entry memory. Status lives in flip-flops in the top level.
  typedef struct packed {
    logic [2:0]         kind;
    logic [7:0]         remaining;
    logic signed [63:0] acc;
    logic [31:0]        payload;
  } entry_t;

endpackage

`default_nettype wire

@@ design/reply_reorder_buffer.sv @@
// Top level of the reply reorder buffer: command decode, ring pointers, entry status, drain walk.
// Depends on rrb_pkg, rrb_entry_ram and assert_macros.svh.
//
//   Channel   Signals                      Handshake
//   --------  ---------------------------  ------------------------------------------
//   request   start, busy, req_i           taken at a clock edge with start high, busy low
//   result    result_valid_o, rsp_o        one cycle per result, cannot be held off
//
// Reserve, fill and begin-aggregate finish in the cycle they are taken; busy stays low.
// A contribution reads the entry from memory in ST_IDLE, then writes it back in ST_CONTRIB.
// A drain returns n replies (n at most 16) in order from the head, one reply per cycle
// from the memory read port; a drain whose head entry is not ready gives one RES_NONE result.
// Each result appears in the cycle after the edge that produced it, from an output register.
// Reset clears the pointers and the per-entry status flip-flops; no clearing pass is needed.
`default_nettype none
`include "assert_macros.svh"

module reply_reorder_buffer #(
  parameter int unsigned DEPTH = rrb_pkg::DEPTH_DEFAULT
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          start,
  output logic               busy,
  input  wire rrb_pkg::req_t req_i,
  output logic               result_valid_o,
  output rrb_pkg::rsp_t      rsp_o
);
  import rrb_pkg::*;

  localparam int unsigned PW = $clog2(DEPTH);
  localparam int unsigned OW = $clog2(DEPTH + 1);
  localparam logic [PW:0]   DEPTH_P = (PW + 1)'(DEPTH);
  localparam logic [OW-1:0] FULL    = OW'(DEPTH);
  localparam logic [PW-1:0] LAST_POS = PW'(DEPTH - 1);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CONTRIB,
    ST_DRAIN
  } state_e;

  // Fold a ring position that may have run past the end back into range.
  function automatic logic [PW-1:0] wrap_pos(input logic [PW:0] sum);
    logic [PW:0] adj;
    adj = sum - DEPTH_P;
    return (sum >= DEPTH_P) ? adj[PW-1:0] : sum[PW-1:0];
  endfunction

  state_e             state_q, state_d;
  logic [PW-1:0]      head_q, head_d;
  logic [OW-1:0]      occ_q, occ_d;
  logic [31:0]        base_q, base_d;
  logic [31:0]        next_q, next_d;
  // Per-entry status: pending aggregate, ready reply; neither means empty.
  logic [DEPTH-1:0]   pend_q, pend_d;
  logic [DEPTH-1:0]   rdy_q, rdy_d;
  logic [DRAIN_W-1:0] n_q, n_d;
  logic [PW-1:0]      pos_q, pos_d;
  req_t               req_q, req_d;
  logic               strobe_q, strobe_d;
  rsp_t               rsp_q, rsp_d;

  logic          mem_we;
  logic [PW-1:0] mem_waddr;
  entry_t        mem_wdata;
  logic          mem_re;
  logic [PW-1:0] mem_raddr;
  entry_t        mem_rdata;

  rrb_entry_ram #(
    .DEPTH (DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  // Offset of the addressed number from the oldest live one, and its ring slot.
  logic [31:0]        off;
  logic               hit;
  logic [PW-1:0]      pos_in;
  logic [PW-1:0]      tail_pos;
  logic [PW-1:0]      head_nxt;
  logic signed [63:0] addend;
  logic [7:0]         rem_new;
  logic               more;

  assign off      = req_i.slot_number - base_q;
  assign hit      = off < 32'(occ_q);
  assign pos_in   = wrap_pos({1'b0, head_q} + off[PW:0]);
  assign tail_pos = wrap_pos({1'b0, head_q} + (PW + 1)'(occ_q));
  assign head_nxt = (head_q == LAST_POS) ? '0 : head_q + 1'b1;

  always_comb begin
    state_d   = state_q;
    head_d    = head_q;
    occ_d     = occ_q;
    base_d    = base_q;
    next_d    = next_q;
    pend_d    = pend_q;
    rdy_d     = rdy_q;
    n_d       = n_q;
    pos_d     = pos_q;
    req_d     = req_q;
    strobe_d  = 1'b0;
    rsp_d     = rsp_q;
    mem_we    = 1'b0;
    mem_waddr = pos_in;
    mem_wdata = '0;
    mem_re    = 1'b0;
    mem_raddr = pos_in;
    addend    = '0;
    rem_new   = '0;
    more      = 1'b0;

    case (state_q)
      ST_IDLE: begin
        if (start) begin
          req_d = req_i;
          case (req_i.command)
            CMD_RESERVE: begin
              strobe_d = 1'b1;
              rsp_d    = '0;
              rsp_d.last = 1'b1;
              if (occ_q == FULL) begin
                rsp_d.result_kind = RES_FULL;
              end else begin
                rsp_d.result_kind     = RES_GRANT;
                rsp_d.slot_number_res = next_q;
                pend_d[tail_pos]      = 1'b0;
                rdy_d[tail_pos]       = 1'b0;
                occ_d                 = occ_q + 1'b1;
                next_d                = next_q + 32'd1;
              end
            end
            CMD_FILL: begin
              if (hit) begin
                mem_we            = 1'b1;
                mem_wdata.kind    = RK_PLAIN;
                mem_wdata.payload = req_i.payload;
                rdy_d[pos_in]     = 1'b1;
                pend_d[pos_in]    = 1'b0;
              end
            end
            CMD_BEGIN: begin
              if (hit) begin
                mem_we              = 1'b1;
                mem_wdata.kind      = {1'b0, req_i.agg_kind} + 3'd1;
                mem_wdata.remaining = req_i.parts_expected;
                mem_wdata.acc       = req_i.count_value;
                pend_d[pos_in]      = 1'b1;
                rdy_d[pos_in]       = 1'b0;
              end
            end
            CMD_PART, CMD_COUNT: begin
              // Contributions to entries that are not pending are dropped here.
              if (hit && pend_q[pos_in]) begin
                mem_re  = 1'b1;
                pos_d   = pos_in;
                state_d = ST_CONTRIB;
              end
            end
            CMD_DRAIN: begin
              if (occ_q != '0 && rdy_q[head_q]) begin
                mem_re    = 1'b1;
                mem_raddr = head_q;
                n_d       = '0;
                state_d   = ST_DRAIN;
              end else begin
                strobe_d          = 1'b1;
                rsp_d             = '0;
                rsp_d.result_kind = RES_NONE;
                rsp_d.last        = 1'b1;
              end
            end
            default: begin
            end
          endcase
        end
      end

      ST_CONTRIB: begin
        // Write back the entry read in the previous cycle.
        addend  = (req_q.command == CMD_COUNT) ? req_q.count_value : '0;
        rem_new = mem_rdata.remaining;
        if (mem_rdata.remaining != 8'd0) begin
          rem_new = mem_rdata.remaining - 8'd1;
          if (mem_rdata.remaining == 8'd1) begin
            rdy_d[pos_q]  = 1'b1;
            pend_d[pos_q] = 1'b0;
          end
        end
        mem_we              = 1'b1;
        mem_waddr           = pos_q;
        mem_wdata           = mem_rdata;
        mem_wdata.remaining = rem_new;
        mem_wdata.acc       = mem_rdata.acc + addend;
        state_d             = ST_IDLE;
      end

      ST_DRAIN: begin
        // The head entry is ready and its memory word is on the read port.
        more = (occ_q != OW'(1)) && (n_q != DRAIN_W'(MAX_DRAIN - 1)) && rdy_q[head_nxt];
        strobe_d              = 1'b1;
        rsp_d                 = '0;
        rsp_d.result_kind     = RES_DRAINED;
        rsp_d.slot_number_res = base_q;
        rsp_d.reply_kind      = mem_rdata.kind;
        if (mem_rdata.kind == RK_PLAIN) begin
          rsp_d.payload_res = mem_rdata.payload;
        end else begin
          rsp_d.count_value_res = mem_rdata.acc;
        end
        rsp_d.last     = !more;
        rdy_d[head_q]  = 1'b0;
        head_d         = head_nxt;
        occ_d          = occ_q - 1'b1;
        base_d         = base_q + 32'd1;
        n_d            = n_q + 1'b1;
        mem_raddr      = head_nxt;
        if (more) begin
          mem_re = 1'b1;
        end else begin
          state_d = ST_IDLE;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      head_q   <= '0;
      occ_q    <= '0;
      base_q   <= '0;
      next_q   <= '0;
      pend_q   <= '0;
      rdy_q    <= '0;
      n_q      <= '0;
      pos_q    <= '0;
      req_q    <= '0;
      strobe_q <= 1'b0;
      rsp_q    <= '0;
    end else begin
      state_q  <= state_d;
      head_q   <= head_d;
      occ_q    <= occ_d;
      base_q   <= base_d;
      next_q   <= next_d;
      pend_q   <= pend_d;
      rdy_q    <= rdy_d;
      n_q      <= n_d;
      pos_q    <= pos_d;
      req_q    <= req_d;
      strobe_q <= strobe_d;
      rsp_q    <= rsp_d;
    end
  end

  assign busy           = (state_q != ST_IDLE);
  assign result_valid_o = strobe_q;
  assign rsp_o          = rsp_q;

  `ASSERT_ALWAYS(a_occ_bound, occ_q <= FULL, "occupancy exceeds ring depth")
  `ASSERT_ALWAYS(a_status_excl, (pend_q & rdy_q) == '0, "entry both pending and ready")
  `ASSERT_ALWAYS(a_num_span, (next_q - base_q) == 32'(occ_q), "sequence span differs from occupancy")
  `ASSERT_CLK(a_drain_ready, state_q == ST_DRAIN |-> rdy_q[head_q] && occ_q != '0, "drain on non-ready head")
  `ASSERT_CLK(a_contrib_wb, state_q == ST_CONTRIB |=> state_q == ST_IDLE && $past(pend_q[pos_q]), "contribution write-back broken")

endmodule

`default_nettype wire

@@ design/rrb_entry_ram.sv @@
// Entry memory of the reply reorder buffer: one write port, one registered read port.
// Depends on rrb_pkg for the entry layout.
`default_nettype none

module rrb_entry_ram #(
  parameter int unsigned DEPTH = rrb_pkg::DEPTH_DEFAULT
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire rrb_pkg::entry_t          wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output rrb_pkg::entry_t               rdata_o
);
  import rrb_pkg::*;

  entry_t mem [DEPTH];
  entry_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire
